// File: rtl/sha_pkg.sv
// shared types, constants and functions for the sha-256 message hasher
package sha_pkg;

    localparam int LenBits = 61;
    localparam int BlkBits = 6;
    localparam int QDepth  = 4;
    localparam int QAw     = 2;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam t_word K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word HInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/sha_front.sv
// input queue between the stream port and the compression engine
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output sha_pkg::t_item o_item
);
    sha_pkg::t_item r_mem [sha_pkg::QDepth];
    logic [sha_pkg::QAw-1:0] r_wp, r_rp;
    logic [sha_pkg::QAw:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 3'(sha_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    // empty items that neither carry a byte nor end a message are dropped here
    assign push    = i_valid && o_ready && (i_item.valid || i_item.last);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(sha_pkg::QDepth)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 3'd1)) else $error("count slip");
endmodule

// File: rtl/sha_core.sv
// byte packing, padding, 64-round compression and digest output
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sha_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last
);
    sha_pkg::t_state r_state, n_state;
    sha_pkg::t_word r_h [8];
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    logic [sha_pkg::LenBits-1:0] r_len;
    logic [5:0] r_rnd;
    logic [2:0] r_oi;
    logic       r_fin;   // current block ends with digest
    logic       r_two;   // pad needs second block
    logic       r_pend;  // byte with end: padding follows the block

    logic [5:0] pos;
    logic [3:0] wi;
    logic [4:0] sh;
    sha_pkg::t_word w_t, s0, s1, t1, t2, e, a, x2, x15;
    logic [63:0] bits;
    logic take;

    assign pos  = r_len[5:0];
    assign wi   = pos[5:2];
    assign sh   = 5'((5'd3 - {3'b0, pos[1:0]}) * 5'd8);
    assign bits = 64'(r_len) << 3;

    assign x2  = r_w[4'(r_rnd - 6'd2)];
    assign x15 = r_w[4'(r_rnd - 6'd15)];
    assign s1  = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
    assign s0  = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
    assign w_t = (r_rnd >= 6'd16) ? s1 + r_w[4'(r_rnd - 6'd7)] + s0 + r_w[r_rnd[3:0]]
                                  : r_w[r_rnd[3:0]];
    assign e   = r_v[4];
    assign a   = r_v[0];
    assign t1  = r_v[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
               + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::K[r_rnd] + w_t;
    assign t2  = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
               + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign take = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                if (take) begin
                    if (i_item.valid && pos == 6'd63) n_state = sha_pkg::ST_ROUND;
                    else if (i_item.last)             n_state = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:   n_state = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND: if (r_rnd == 6'd63) n_state = sha_pkg::ST_ADD;
            sha_pkg::ST_ADD: begin
                if (r_pend)     n_state = sha_pkg::ST_PAD;
                else if (r_two) n_state = sha_pkg::ST_ROUND;
                else if (r_fin) n_state = sha_pkg::ST_OUT;
                else            n_state = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_OUT: if (i_ready && r_oi == 3'd7) n_state = sha_pkg::ST_IDLE;
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == sha_pkg::ST_IDLE);
        o_valid = (r_state == sha_pkg::ST_OUT);
        o_word  = r_h[r_oi];
        o_index = r_oi;
        o_last  = (r_oi == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_rnd  <= '0;
            r_oi   <= '0;
            r_fin  <= 1'b0;
            r_two  <= 1'b0;
            r_pend <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::HInit[i];
                r_v[i] <= '0;
            end
        end else begin
            unique case (r_state)
                sha_pkg::ST_IDLE: begin
                    if (take) begin
                        if (i_item.valid) begin
                            if (pos[1:0] == 2'd0) r_w[wi] <= {i_item.data, 24'h0};
                            else r_w[wi] <= r_w[wi] | (32'(i_item.data) << sh);
                            r_len <= r_len + 1'b1;
                            if (pos == 6'd63) begin
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                                r_rnd  <= '0;
                                r_pend <= i_item.last;
                                r_fin  <= 1'b0;
                                r_two  <= 1'b0;
                            end
                        end
                    end
                end
                sha_pkg::ST_PAD: begin
                    for (int i = 0; i < 16; i++) begin
                        if (i > int'(wi)) r_w[i] <= '0;
                    end
                    if (pos[1:0] == 2'd0) r_w[wi] <= 32'h8000_0000;
                    else r_w[wi] <= (r_w[wi] & ~((32'h100 << sh) - 32'h1))
                                  | (32'h80 << sh);
                    if (pos < 6'd56) begin
                        r_w[14] <= bits[63:32];
                        r_w[15] <= bits[31:0];
                        r_two <= 1'b0;
                    end else begin
                        r_two <= 1'b1;
                    end
                    r_fin  <= 1'b1;
                    r_pend <= 1'b0;
                    r_rnd  <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                sha_pkg::ST_ROUND: begin
                    r_w[r_rnd[3:0]] <= w_t;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 1'b1;
                end
                sha_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        if (r_two) r_v[i] <= r_h[i] + r_v[i];
                    end
                    if (r_two) begin
                        for (int i = 0; i < 14; i++) r_w[i] <= '0;
                        r_w[14] <= bits[63:32];
                        r_w[15] <= bits[31:0];
                        r_two   <= 1'b0;
                        r_rnd   <= '0;
                    end
                    r_oi <= '0;
                end
                sha_pkg::ST_OUT: begin
                    if (i_ready) begin
                        r_oi <= r_oi + 1'b1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha_pkg::HInit[i];
                                r_v[i] <= '0;
                            end
                            r_len <= '0;
                            r_fin <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && r_oi != 3'd7) |=> (r_oi == $past(r_oi) + 3'd1))
        else $error("digest index skipped");
    a_round_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::ST_ROUND && r_rnd == 6'd63) |=> (r_state == sha_pkg::ST_ADD))
        else $error("round count slip");
    a_out_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::ST_OUT) |-> r_fin) else $error("digest without end");
endmodule

// File: rtl/sha256_message_hasher.sv
// top level of the sha-256 message hasher
//  channel | dir | tdata (low bit up)        | tuser      | tlast
//  s_axis  | in  | data_byte[7:0]            | byte_valid | last_byte
//  m_axis  | out | digest_word[31:0]         | word_index | last_word
// a byte is registered into the queue, then packed into the block when the core is idle and takes it
// a full 64-byte block is compressed at one round a cycle, followed by the final add
// the message end goes through a pad step plus one or two blocks, then 8 output words
// the four-entry queue keeps taking bytes while a block compresses, until it is full
// i_rst_n is synchronous, active low, and restores the initial hash values
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    sha_pkg::t_item in_item, q_item;
    logic q_valid, q_ready;

    assign in_item = '{data: s_axis_tdata, valid: s_axis_tuser, last: s_axis_tlast};

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (m_axis_tdata),
        .o_index (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );
endmodule
